### rtl/core/dsts_pkg.sv
// ----------------------------------------------------------------------------
// dsts_pkg
// shared types, codes and sizes for the deadline sorted timer set
// ----------------------------------------------------------------------------
package dsts_pkg;

	localparam int TIMER_COUNT_DEF = 8;
	localparam int FIRE_LIMIT_DEF  = 64;
	localparam int IDX_EXT_W       = 6;
	localparam int DIV_DVD_W       = 64;
	localparam int DIV_DVS_W       = 20;

	localparam logic [19:0] TICK_US_RST = 20'd1000;
	localparam logic [19:0] MS_US       = 20'd1000;

	localparam logic [2:0] ACT_INIT   = 3'd0;
	localparam logic [2:0] ACT_START  = 3'd1;
	localparam logic [2:0] ACT_STOP   = 3'd2;
	localparam logic [2:0] ACT_STATUS = 3'd3;
	localparam logic [2:0] ACT_REM_MS = 3'd4;
	localparam logic [2:0] ACT_REM_TK = 3'd5;
	localparam logic [2:0] ACT_EXP_TK = 3'd6;
	localparam logic [2:0] ACT_ADV    = 3'd7;

	localparam logic [1:0] EV_EXPIRED = 2'd0;
	localparam logic [1:0] EV_STOPPED = 2'd1;
	localparam logic [1:0] EV_REPLY   = 2'd2;
	localparam logic [1:0] EV_REFUSED = 2'd3;

	typedef struct packed {
		logic [63:0] deadline;
		logic [31:0] period;
		logic [31:0] count;
		logic        running;
		logic        periodic;
		logic        init;
		logic [31:0] order;
	} tmr_entry_t;

endpackage

### rtl/core/deadline_sorted_timer_set.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_set
// microsecond timers on one uptime counter, fired earliest deadline first
// ----------------------------------------------------------------------------
// channel  | signals                                         | direction
// in       | in_valid in_ready action timer_index            | into block
//          | delay_us reload_us elapsed_us                   |
// out      | out_valid out_ready event_res timer_index_res   | out of block
//          | value last                                      |
// cfg      | cfg_we cfg_wdata (tick_us)                      | into block
//
// one transaction at a time; in_ready only while the sequencer is idle
// init/start/stop/status are handled in the op state; ms and tick queries wait on
//   the shared 64-step divider
// advance: before each firing the timer table is scanned entry by entry
//   through its single read port, at most FIRE_LIMIT firings
// result register decouples the out side; a stalled out only holds the sequencer
// reset clears uptime, all timers and sets tick_us to 1000
// ----------------------------------------------------------------------------
module deadline_sorted_timer_set #(
	parameter int TIMER_COUNT = dsts_pkg::TIMER_COUNT_DEF,
	parameter int FIRE_LIMIT  = dsts_pkg::FIRE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [2:0]  timer_index,
	input  logic [31:0] delay_us,
	input  logic [31:0] reload_us,
	input  logic [15:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [2:0]  timer_index_res,
	output logic [62:0] value,
	output logic        last,
	input  logic        cfg_we,
	input  logic [19:0] cfg_wdata
);
	import dsts_pkg::*;

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int FW = $clog2(FIRE_LIMIT + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OP   = 3'd1;
	localparam logic [2:0] S_DIVW = 3'd2;
	localparam logic [2:0] S_DIVO = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_SEND = 3'd5;
	localparam logic [2:0] S_FIRE = 3'd6;

	logic [2:0]  state_q, state_d;
	logic [19:0] tick_q;
	logic [62:0] uptime_q;
	logic [31:0] next_order_q;
	logic [2:0]  act_q, idx_q;
	logic [31:0] dur_q, per_q;

	// advance scan bookkeeping
	logic [IW-1:0] scan_q, best_q, pend_q;
	logic [63:0]   best_dl_q;
	logic [31:0]   best_ord_q;
	logic          found_q, have_pend_q;
	logic [FW-1:0] fires_q;

	// result register
	logic        out_valid_q, out_last_q;
	logic [1:0]  out_ev_q;
	logic [2:0]  out_idx_q;
	logic [62:0] out_val_q;

	// sequencer outputs
	logic        emit, emit_last;
	logic [1:0]  emit_ev;
	logic [2:0]  emit_idx;
	logic [62:0] emit_val;
	logic        wr_en, div_start;
	tmr_entry_t  wr_data, rd;
	logic [IW-1:0] rd_addr;

	logic          out_free, in_acc;
	logic [IDX_EXT_W-1:0] idx_ext, pend_ext;
	logic [19:0]   eff_tick;
	logic [63:0]   up64, rem_us, up_sum;
	logic [63:0]   div_dvd;
	logic [19:0]   div_dvs;
	logic          div_busy;
	logic [63:0]   div_quo, tk_ceil;
	logic [19:0]   div_rem;
	logic          due, better;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign eff_tick = (tick_q == '0) ? 20'd1 : tick_q;
	assign up64     = {1'b0, uptime_q};
	assign up_sum   = up64 + {48'd0, elapsed_us};
	assign idx_ext  = {3'b000, idx_q};
	assign pend_ext = IDX_EXT_W'(pend_q);

	// table read address follows the sequencer step
	always_comb begin
		unique case (state_q)
			S_SCAN:  rd_addr = scan_q;
			S_FIRE:  rd_addr = best_q;
			default: rd_addr = idx_ext[IW-1:0];
		endcase
	end

	dsts_tbl #(.TIMER_COUNT(TIMER_COUNT), .IW(IW)) u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (rd_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd)
	);

	// remaining time, zero when stopped or already due
	assign rem_us = (rd.running && rd.init && rd.deadline > up64) ?
		rd.deadline - up64 : 64'd0;

	always_comb begin
		unique case (act_q)
			ACT_REM_MS: begin
				div_dvd = rem_us;
				div_dvs = MS_US;
			end
			ACT_REM_TK: begin
				div_dvd = rem_us;
				div_dvs = eff_tick;
			end
			default: begin
				div_dvd = (rd.running && rd.init) ? rd.deadline : up64;
				div_dvs = eff_tick;
			end
		endcase
	end

	dsts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign tk_ceil = div_quo + {63'd0, div_rem != '0};

	// scan compare: due now, and earlier than the best so far (ties by arm order)
	assign due    = rd.running && rd.deadline <= up64;
	assign better = !found_q || rd.deadline < best_dl_q ||
		(rd.deadline == best_dl_q && rd.order < best_ord_q);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		emit_last = 1'b1;
		emit_ev   = EV_REPLY;
		emit_idx  = idx_q;
		emit_val  = '0;
		wr_en     = 1'b0;
		wr_data   = rd;
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (action == ACT_ADV) state_d = S_SCAN;
					else if (32'(timer_index) < TIMER_COUNT) state_d = S_OP;
				end
			end
			S_OP: begin
				unique case (act_q)
					ACT_INIT: begin
						wr_en        = 1'b1;
						wr_data      = '0;
						wr_data.init = 1'b1;
						state_d      = S_IDLE;
					end
					ACT_START: begin
						if (!rd.init) begin
							emit_ev = EV_REFUSED;
							if (out_free) begin
								emit    = 1'b1;
								state_d = S_IDLE;
							end
						end else begin
							wr_en            = 1'b1;
							wr_data.count    = '0;
							wr_data.periodic = per_q != '0;
							wr_data.period   = per_q;
							wr_data.deadline = up64 + {32'd0, dur_q};
							wr_data.order    = next_order_q;
							wr_data.running  = 1'b1;
							state_d          = S_IDLE;
						end
					end
					ACT_STOP: begin
						emit_ev = EV_STOPPED;
						if (!rd.running) begin
							state_d = S_IDLE;
						end else if (out_free) begin
							emit            = 1'b1;
							wr_en           = 1'b1;
							wr_data.running = 1'b0;
							state_d         = S_IDLE;
						end
					end
					ACT_STATUS: begin
						emit_val = {31'd0, rd.count};
						if (out_free) begin
							emit          = 1'b1;
							wr_en         = 1'b1;
							wr_data.count = '0;
							state_d       = S_IDLE;
						end
					end
					default: begin
						div_start = 1'b1;
						state_d   = S_DIVW;
					end
				endcase
			end
			S_DIVW: begin
				if (!div_busy) state_d = S_DIVO;
			end
			S_DIVO: begin
				unique case (act_q)
					ACT_REM_MS: emit_val = (div_quo[63:32] != '0) ?
						63'h0_FFFF_FFFF : div_quo[62:0];
					ACT_REM_TK: emit_val = tk_ceil[62:0];
					default:    emit_val = div_quo[62:0];
				endcase
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (scan_q == IW'(TIMER_COUNT - 1)) state_d = S_SEND;
			end
			S_SEND: begin
				emit_ev   = EV_EXPIRED;
				emit_idx  = pend_ext[2:0];
				if (found_q && fires_q < FW'(FIRE_LIMIT)) begin
					emit_last = 1'b0;
					if (!have_pend_q) begin
						state_d = S_FIRE;
					end else if (out_free) begin
						emit    = 1'b1;
						state_d = S_FIRE;
					end
				end else if (!have_pend_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIRE: begin
				wr_en         = 1'b1;
				wr_data.count = rd.count + 32'd1;
				if (rd.periodic) begin
					wr_data.deadline = rd.deadline + {32'd0, rd.period};
					wr_data.order    = next_order_q;
				end else begin
					wr_data.running = 1'b0;
				end
				state_d = S_SCAN;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tick_q       <= TICK_US_RST;
			uptime_q     <= '0;
			next_order_q <= '0;
			found_q      <= 1'b0;
			have_pend_q  <= 1'b0;
			fires_q      <= '0;
			scan_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) tick_q <= cfg_wdata;
			if (in_acc && action == ACT_ADV) begin
				// saturating uptime add
				uptime_q    <= up_sum[63] ? {63{1'b1}} : up_sum[62:0];
				found_q     <= 1'b0;
				have_pend_q <= 1'b0;
				fires_q     <= '0;
				scan_q      <= '0;
			end
			if (state_q == S_OP && act_q == ACT_START && rd.init)
				next_order_q <= next_order_q + 32'd1;
			if (state_q == S_SCAN) begin
				if (due && better) found_q <= 1'b1;
				if (scan_q != IW'(TIMER_COUNT - 1)) scan_q <= scan_q + 1'b1;
			end
			if (state_q == S_FIRE) begin
				if (rd.periodic) next_order_q <= next_order_q + 32'd1;
				have_pend_q <= 1'b1;
				fires_q     <= fires_q + 1'b1;
				found_q     <= 1'b0;
				scan_q      <= '0;
			end
			if (state_q == S_SEND && state_d == S_IDLE) have_pend_q <= 1'b0;
			if (emit)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= action;
			idx_q <= timer_index;
			dur_q <= delay_us;
			per_q <= reload_us;
		end
		if (state_q == S_SCAN && due && better) begin
			best_q     <= scan_q;
			best_dl_q  <= rd.deadline;
			best_ord_q <= rd.order;
		end
		if (state_q == S_FIRE) pend_q <= best_q;
		if (emit) begin
			out_ev_q   <= emit_ev;
			out_idx_q  <= emit_idx;
			out_val_q  <= emit_val;
			out_last_q <= emit_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = out_ev_q;
	assign timer_index_res = out_idx_q;
	assign value           = out_val_q;
	assign last            = out_last_q;

	// firings per advance never pass the limit
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		fires_q <= FW'(FIRE_LIMIT))
		else $error("fire count over limit");

	// divider only runs while the sequencer waits on it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == S_DIVW)
		else $error("divider busy outside wait");

	// no expiry left pending once back to idle
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !have_pend_q)
		else $error("pending expiry at idle");

	// a result is never overwritten before it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result overrun");

endmodule

### rtl/core/dsts_div.sv
// ----------------------------------------------------------------------------
// dsts_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dsts_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [dsts_pkg::DIV_DVD_W-1:0] dividend,
	input  logic [dsts_pkg::DIV_DVS_W-1:0] divisor,
	output logic                           busy,
	output logic [dsts_pkg::DIV_DVD_W-1:0] quotient,
	output logic [dsts_pkg::DIV_DVS_W-1:0] remainder
);
	import dsts_pkg::*;

	localparam int CW = $clog2(DIV_DVD_W);

	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [DIV_DVS_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(DIV_DVD_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_DVD_W-2:0], fits};
			rem_q <= fits ? DIV_DVS_W'(trial - {1'b0, dvs_q}) : trial[DIV_DVS_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/core/dsts_tbl.sv
// ----------------------------------------------------------------------------
// dsts_tbl
// per-timer state, one read port and one write port
// ----------------------------------------------------------------------------
module dsts_tbl #(
	parameter int TIMER_COUNT = dsts_pkg::TIMER_COUNT_DEF,
	parameter int IW          = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [IW-1:0]        wr_addr,
	input  dsts_pkg::tmr_entry_t wr_data,
	input  logic [IW-1:0]        rd_addr,
	output dsts_pkg::tmr_entry_t rd_data
);
	import dsts_pkg::*;

	tmr_entry_t ent_q [TIMER_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) ent_q[i] <= '0;
		end else if (wr_en) begin
			ent_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = ent_q[rd_addr];

endmodule
